// File: rtl/core/x86_64_instruction_encoder_core_defines.svh
// Assertion shorthands for the encoder core; only x86enc_back includes them.
// Each expects clk and rst_n in scope.
`ifndef X86_64_INSTRUCTION_ENCODER_CORE_DEFINES_SVH
`define X86_64_INSTRUCTION_ENCODER_CORE_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define X86ENC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define X86ENC_NEVER(lbl, cond, msg) \
  `X86ENC_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/x86enc_pkg.sv
`timescale 1ns / 1ps

package x86enc_pkg;

  localparam int unsigned CodeBytes = 4096;
  localparam int unsigned PtrW      = $clog2(CodeBytes + 1);
  localparam int unsigned OffW      = 12;
  localparam int unsigned MaxBytes  = 12;
  localparam int unsigned IdxW      = $clog2(MaxBytes);
  localparam int unsigned RelW      = ((PtrW > OffW) ? PtrW : OffW) + 2;

  // Instruction forms
  localparam logic [3:0] OP_PLAIN      = 4'd0;
  localparam logic [3:0] OP_PLUS_REG   = 4'd1;
  localparam logic [3:0] OP_REXW_IMM64 = 4'd2;
  localparam logic [3:0] OP_REX_MODRM  = 4'd3;
  localparam logic [3:0] OP_MODRM_EXT  = 4'd4;
  localparam logic [3:0] OP_MODRM_IMM32 = 4'd5;
  localparam logic [3:0] OP_REL8       = 4'd6;
  localparam logic [3:0] OP_REL32      = 4'd7;
  localparam logic [3:0] OP_JCC        = 4'd8;

  localparam logic [7:0] REX_W      = 8'h48;
  localparam logic [7:0] JCC_SHORT  = 8'h70;
  localparam logic [7:0] ESC_0F     = 8'h0f;
  localparam logic [7:0] JCC_NEAR   = 8'h80;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_DIRECT = 2'b11;
  localparam logic [3:0] RM_SIB     = 4'd4;

  // One encoded instruction (or one overflow marker) waiting for the back end
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
    logic [OffW-1:0]          base;
    logic                     ovf;
  } ent_t;

endpackage

// File: rtl/core/x86enc_front.sv
`timescale 1ns / 1ps

module x86enc_front import x86enc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              q_full,
  input  logic [3:0]        in_operation,
  input  logic [7:0]        in_opcode,
  input  logic [3:0]        in_reg_code,
  input  logic [3:0]        in_rm_code,
  input  logic [1:0]        in_addr_mode,
  input  logic signed [31:0] in_displacement,
  input  logic [1:0]        in_sib_scale,
  input  logic [3:0]        in_sib_index,
  input  logic [3:0]        in_sib_base,
  input  logic [63:0]       in_immediate,
  input  logic [11:0]       in_jump_target,
  output logic              q_push,
  output ent_t              q_ent
);

  logic [PtrW-1:0] wp_r;
  logic            full_r;

  logic            use_sib;
  logic [7:0]      rex, modrm, sib, opc_reg;
  logic [31:0]     disp_part;
  logic [2:0]      dlen, tlen;
  logic [47:0]     tail;
  logic [3:0]      imm_pos;
  logic signed [RelW-1:0] rel_full, rel_near;
  logic            fits8;
  logic [31:0]     rel32;
  logic [95:0]     code;
  logic [3:0]      n;
  logic            op_ok;
  logic [PtrW:0]   end_ptr;
  logic            ovf;

  always_comb begin
    use_sib = (in_rm_code == RM_SIB) && (in_addr_mode != MOD_DIRECT);
    rex     = REX_W | {5'b0, in_reg_code[3], use_sib & in_sib_index[3],
                       use_sib ? in_sib_base[3] : in_rm_code[3]};
    modrm   = {in_addr_mode, in_reg_code[2:0], in_rm_code[2:0]};
    sib     = {in_sib_scale, in_sib_index[2:0], in_sib_base[2:0]};
    opc_reg = in_opcode + {4'b0, in_reg_code};

    case (in_addr_mode)
      MOD_DISP8: begin
        disp_part = {24'b0, in_displacement[7:0]};
        dlen      = 3'd1;
      end
      MOD_DISP32: begin
        disp_part = in_displacement;
        dlen      = 3'd4;
      end
      default: begin
        disp_part = '0;
        dlen      = 3'd0;
      end
    endcase

    // ModRM, optional SIB, then displacement
    tail = {40'b0, modrm}
         | (use_sib ? {32'b0, sib, 8'b0} : 48'b0)
         | (use_sib ? {disp_part, 16'b0} : {8'b0, disp_part, 8'b0});
    tlen = 3'd1 + {2'b0, use_sib} + dlen;
    imm_pos = 4'(tlen) + 4'd2;

    // Conditional jump displacement, relative to end of short or near form
    rel_full = $signed({{(RelW-OffW){1'b0}}, in_jump_target})
             - $signed({{(RelW-PtrW){1'b0}}, wp_r}) - RelW'(2);
    rel_near = rel_full - RelW'(4);
    fits8    = (rel_full[RelW-1:7] == '0) || (rel_full[RelW-1:7] == '1);
    rel32    = {{(32-RelW){rel_near[RelW-1]}}, rel_near};

    op_ok = 1'b1;
    case (in_operation)
      OP_PLAIN: begin
        code = {88'b0, in_opcode};
        n    = 4'd1;
      end
      OP_PLUS_REG: begin
        code = {88'b0, opc_reg};
        n    = 4'd1;
      end
      OP_REXW_IMM64: begin
        code = {16'b0, in_immediate, opc_reg, REX_W};
        n    = 4'd10;
      end
      OP_REX_MODRM: begin
        code = {32'b0, tail, in_opcode, rex};
        n    = 4'(tlen) + 4'd2;
      end
      OP_MODRM_EXT: begin
        code = {40'b0, tail, in_opcode};
        n    = 4'(tlen) + 4'd1;
      end
      OP_MODRM_IMM32: begin
        code = {32'b0, tail, in_opcode, rex}
             | ({64'b0, in_immediate[31:0]} << {imm_pos, 3'b0});
        n    = 4'(tlen) + 4'd6;
      end
      OP_REL8: begin
        code = {80'b0, in_displacement[7:0], in_opcode};
        n    = 4'd2;
      end
      OP_REL32: begin
        code = {56'b0, in_displacement, in_opcode};
        n    = 4'd5;
      end
      OP_JCC: begin
        if (fits8) begin
          code = {80'b0, rel_full[7:0], JCC_SHORT + {4'b0, in_opcode[3:0]}};
          n    = 4'd2;
        end else begin
          code = {48'b0, rel32, JCC_NEAR + {4'b0, in_opcode[3:0]}, ESC_0F};
          n    = 4'd6;
        end
      end
      default: begin
        code  = '0;
        n     = 4'd0;
        op_ok = 1'b0;
      end
    endcase

    end_ptr = {1'b0, wp_r} + (PtrW+1)'(n);
    ovf     = full_r || (end_ptr > (PtrW+1)'(CodeBytes));
    q_push  = in_push && !q_full && op_ok;

    if (ovf) begin
      q_ent.bytes    = '0;
      q_ent.last_idx = '0;
    end else begin
      q_ent.bytes    = code;
      q_ent.last_idx = IdxW'(n - 4'd1);
    end
    q_ent.base = OffW'(wp_r);
    q_ent.ovf  = ovf;
  end

  // Advance the pointer on a fitting instruction; latch full otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (q_push) begin
      if (ovf) begin
        full_r <= 1'b1;
      end else begin
        wp_r <= end_ptr[PtrW-1:0];
      end
    end
  end

endmodule

// File: rtl/core/x86enc_fifo.sv
`timescale 1ns / 1ps

module x86enc_fifo import x86enc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ent_t push_ent,
  output logic full,
  input  logic pop,
  output ent_t pop_ent,
  output logic empty
);

  ent_t       mem_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_ent = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/core/x86enc_back.sv
`timescale 1ns / 1ps
`include "x86_64_instruction_encoder_core_defines.svh"

module x86enc_back import x86enc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  ent_t        q_ent,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [7:0]  out_code_byte,
  output logic [11:0] out_byte_offset,
  output logic        out_last_byte,
  output logic        out_overflow
);

  ent_t            cur_r;
  logic            valid_r;
  logic [IdxW-1:0] idx_r;
  logic            take;

  assign out_empty       = !valid_r;
  assign out_code_byte   = cur_r.bytes[idx_r];
  assign out_byte_offset = cur_r.base + OffW'(idx_r);
  assign out_last_byte   = (idx_r == cur_r.last_idx);
  assign out_overflow    = cur_r.ovf;

  // Load the next entry when idle or when the last beat goes out
  assign take  = !valid_r || (out_pop && out_last_byte);
  assign q_pop = take && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= !q_empty;
      idx_r   <= '0;
    end else if (out_pop) begin
      idx_r <= idx_r + IdxW'(1);
    end
  end

  `X86ENC_ASSERT(a_idx_bound, valid_r |-> idx_r <= cur_r.last_idx, "byte index past end")
  `X86ENC_NEVER(a_ovf_single, valid_r && cur_r.ovf && cur_r.last_idx != '0, "overflow multi-beat")
  `X86ENC_ASSERT(a_offset_step, valid_r && out_pop && !out_last_byte |=> valid_r && out_byte_offset == $past(out_byte_offset) + 12'd1, "offset did not step")

endmodule

// File: rtl/core/x86_64_instruction_encoder_core.sv
`timescale 1ns / 1ps

// x86-64 encoder: push one instruction descriptor per beat, pop its machine
// code one byte per beat, each tagged with its code buffer offset and a flag
// on the final byte. Instructions are 1 to 12 bytes; a byte leaves every cycle
// the consumer pops, and the sustained rate is set by the byte serializer (one
// byte per cycle). The front end classifies an item in the cycle it is
// accepted and can take one every cycle while the two-entry queue has room, so
// it runs ahead of the serializer by up to two instructions plus the one in
// flight. A pushed item is registered in the queue and then in the serializer
// before its first byte is visible. An item that would run past the end of the
// code buffer gives a single beat with overflow set, code 0 and the current
// pointer as offset; from then on every item of a known form gives that beat.
// Unknown forms are accepted and dropped without any result.
module x86_64_instruction_encoder_core import x86enc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [3:0]        in_operation,
  input  logic [7:0]        in_opcode,
  input  logic [3:0]        in_reg_code,
  input  logic [3:0]        in_rm_code,
  input  logic [1:0]        in_addr_mode,
  input  logic signed [31:0] in_displacement,
  input  logic [1:0]        in_sib_scale,
  input  logic [3:0]        in_sib_index,
  input  logic [3:0]        in_sib_base,
  input  logic [63:0]       in_immediate,
  input  logic [11:0]       in_jump_target,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_code_byte,
  output logic [11:0]       out_byte_offset,
  output logic              out_last_byte,
  output logic              out_overflow
);

  logic q_push, q_full, q_pop, q_empty;
  ent_t q_in, q_out;

  // Decode, size check and write pointer
  x86enc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .q_full          (q_full),
    .in_operation    (in_operation),
    .in_opcode       (in_opcode),
    .in_reg_code     (in_reg_code),
    .in_rm_code      (in_rm_code),
    .in_addr_mode    (in_addr_mode),
    .in_displacement (in_displacement),
    .in_sib_scale    (in_sib_scale),
    .in_sib_index    (in_sib_index),
    .in_sib_base     (in_sib_base),
    .in_immediate    (in_immediate),
    .in_jump_target  (in_jump_target),
    .q_push          (q_push),
    .q_ent           (q_in)
  );

  // Hold encoded instructions between the two sides
  x86enc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_ent  (q_out),
    .empty    (q_empty)
  );

  // Drive one byte per beat
  x86enc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_ent           (q_out),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_code_byte   (out_code_byte),
    .out_byte_offset (out_byte_offset),
    .out_last_byte   (out_last_byte),
    .out_overflow    (out_overflow)
  );

  assign in_full = q_full;

endmodule

// File: tb/x86_64_instruction_encoder_core_tb.sv
`timescale 1ns / 1ps

// The encoder takes one instruction descriptor per push and emits its machine
// code one byte per pop. Every byte carries its code buffer offset and a flag
// on the final byte of the instruction. Once an instruction would run past the
// end of the code buffer, the block emits a single overflow beat, and it does
// so for every later item of a known form as well.
module x86_64_instruction_encoder_core_tb;
  import x86enc_pkg::*;

  localparam logic [1:0] MOD_INDIRECT = 2'b00;
  localparam int         IDLE_LIMIT   = 1000;  // cycles with no beat moving on either side
  localparam int         TAIL_CYCLES  = 32;    // settle time once nothing is due
  localparam int         OFF_MAX      = (1 << OffW) - 1;

  // One instruction descriptor, as it sits on the in_ ports
  typedef struct {
    logic [3:0]  operation;
    logic [7:0]  opcode;
    logic [3:0]  reg_code;
    logic [3:0]  rm_code;
    logic [1:0]  addr_mode;
    logic [31:0] displacement;
    logic [1:0]  sib_scale;
    logic [3:0]  sib_index;
    logic [3:0]  sib_base;
    logic [63:0] immediate;
    logic [11:0] jump_target;
  } insn_t;

  // One emitted code byte, as it sits on the out_ ports
  typedef struct {
    logic [7:0]  code;
    logic [11:0] offset;
    logic        last;
    logic        ovf;
  } code_beat_t;

  // Tracks the code buffer write pointer and the overflow state. It turns each
  // accepted instruction into the code beats that the block must emit.
  class code_image_model;
    int unsigned wr_ptr;
    bit          buf_full;
    logic [7:0]  enc_bytes[$];
    code_beat_t  beats_due[$];

    function new();
      wr_ptr   = 0;
      buf_full = 1'b0;
    endfunction

    function void put_le(logic [63:0] v, int cnt);
      for (int i = 0; i < cnt; i++) enc_bytes.push_back(v[8*i +: 8]);
    endfunction

    function void put_modrm(insn_t it, bit sib);
      put_le({it.addr_mode, it.reg_code[2:0], it.rm_code[2:0]}, 1);
      if (sib) put_le({it.sib_scale, it.sib_index[2:0], it.sib_base[2:0]}, 1);
      if (it.addr_mode == MOD_DISP8) put_le(it.displacement, 1);
      else if (it.addr_mode == MOD_DISP32) put_le(it.displacement, 4);
    endfunction

    function void accept_item(insn_t it);
      bit         sib;
      logic [7:0] rex;
      int         rel;
      int         n;
      sib = (it.rm_code == RM_SIB) && (it.addr_mode != MOD_DIRECT);
      rex = REX_W | {5'b0, it.reg_code[3], sib & it.sib_index[3],
                     sib ? it.sib_base[3] : it.rm_code[3]};
      enc_bytes.delete();
      case (it.operation)
        OP_PLAIN: put_le(it.opcode, 1);
        OP_PLUS_REG: put_le(8'(it.opcode + it.reg_code), 1);
        OP_REXW_IMM64: begin
          put_le(REX_W, 1);
          put_le(8'(it.opcode + it.reg_code), 1);
          put_le(it.immediate, 8);
        end
        OP_REX_MODRM: begin
          put_le(rex, 1);
          put_le(it.opcode, 1);
          put_modrm(it, sib);
        end
        OP_MODRM_EXT: begin
          put_le(it.opcode, 1);
          put_modrm(it, sib);
        end
        OP_MODRM_IMM32: begin
          put_le(rex, 1);
          put_le(it.opcode, 1);
          put_modrm(it, sib);
          put_le(it.immediate, 4);
        end
        OP_REL8: begin
          put_le(it.opcode, 1);
          put_le(it.displacement, 1);
        end
        OP_REL32: begin
          put_le(it.opcode, 1);
          put_le(it.displacement, 4);
        end
        OP_JCC: begin
          rel = int'(it.jump_target) - (int'(wr_ptr) + 2);
          if (rel >= -128 && rel <= 127) begin
            put_le(8'(JCC_SHORT + it.opcode[3:0]), 1);
            put_le(rel, 1);
          end else begin
            rel = int'(it.jump_target) - (int'(wr_ptr) + 6);
            put_le(ESC_0F, 1);
            put_le(8'(JCC_NEAR + it.opcode[3:0]), 1);
            put_le(rel, 4);
          end
        end
        default: return;
      endcase
      n = enc_bytes.size();
      if (buf_full || wr_ptr + n > CodeBytes) begin
        buf_full = 1'b1;
        beats_due.push_back('{8'h00, wr_ptr[11:0], 1'b1, 1'b1});
        return;
      end
      for (int k = 0; k < n; k++)
        beats_due.push_back('{enc_bytes[k], 12'(wr_ptr + k), k == n - 1, 1'b0});
      wr_ptr += n;
    endfunction

    // Returns an empty string when the beat matches the oldest one due
    function string check_beat(code_beat_t got);
      code_beat_t want;
      string      msg;
      if (beats_due.size() == 0)
        return $sformatf("beat with nothing due: code_byte %02h byte_offset %0d",
                         got.code, got.offset);
      want = beats_due.pop_front();
      msg  = "";
      if (got.code !== want.code)
        msg = {msg, $sformatf(" code_byte %02h want %02h", got.code, want.code)};
      if (got.offset !== want.offset)
        msg = {msg, $sformatf(" byte_offset %0d want %0d", got.offset, want.offset)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last_byte %b want %b", got.last, want.last)};
      if (got.ovf !== want.ovf)
        msg = {msg, $sformatf(" overflow %b want %b", got.ovf, want.ovf)};
      if (msg != "") msg = {$sformatf("beat at offset %0d:", want.offset), msg};
      return msg;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic [3:0]        in_operation;
  logic [7:0]        in_opcode;
  logic [3:0]        in_reg_code;
  logic [3:0]        in_rm_code;
  logic [1:0]        in_addr_mode;
  logic signed [31:0] in_displacement;
  logic [1:0]        in_sib_scale;
  logic [3:0]        in_sib_index;
  logic [3:0]        in_sib_base;
  logic [63:0]       in_immediate;
  logic [11:0]       in_jump_target;
  logic              out_empty;
  logic              out_pop;
  logic [7:0]        out_code_byte;
  logic [11:0]       out_byte_offset;
  logic              out_last_byte;
  logic              out_overflow;

  code_image_model code_img = new();
  int              mismatches  = 0;
  int              idle_cycles = 0;
  bit              quiet_in    = 1'b0;  // burst with no input gaps
  bit              quiet_out   = 1'b0;  // burst with no pop stalls

  x86_64_instruction_encoder_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_opcode       (in_opcode),
    .in_reg_code     (in_reg_code),
    .in_rm_code      (in_rm_code),
    .in_addr_mode    (in_addr_mode),
    .in_displacement (in_displacement),
    .in_sib_scale    (in_sib_scale),
    .in_sib_index    (in_sib_index),
    .in_sib_base     (in_sib_base),
    .in_immediate    (in_immediate),
    .in_jump_target  (in_jump_target),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_code_byte   (out_code_byte),
    .out_byte_offset (out_byte_offset),
    .out_last_byte   (out_last_byte),
    .out_overflow    (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Mostly back to back, often a short gap, now and then a long one
  function automatic int gap_cycles(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic insn_t mk(logic [3:0] op, logic [7:0] opc, logic [3:0] rg,
                               logic [3:0] rm, logic [1:0] md, logic [31:0] disp,
                               logic [1:0] sc, logic [3:0] ix, logic [3:0] bs,
                               logic [63:0] imm, logic [11:0] tgt);
    insn_t it;
    it = '{op, opc, rg, rm, md, disp, sc, ix, bs, imm, tgt};
    return it;
  endfunction

  // Jump target at a given distance from the short-form origin; clip to the
  // field range when the distance does not fit at the current pointer.
  function automatic logic [11:0] near_target(int reach);
    int tgt;
    tgt = int'(code_img.wr_ptr) + 2 + reach;
    if (tgt < 0) tgt = 0;
    if (tgt > OFF_MAX) tgt = OFF_MAX;
    return 12'(tgt);
  endfunction

  function automatic insn_t rand_insn();
    insn_t it;
    int    r;
    it = mk(4'($urandom_range(0, int'(OP_JCC))), 8'($urandom), 4'($urandom),
            4'($urandom), 2'($urandom), $urandom, 2'($urandom), 4'($urandom),
            4'($urandom), {$urandom, $urandom}, 12'($urandom));
    // a little noise: forms the block drops
    if ($urandom_range(0, 99) < 4) it.operation = 4'($urandom_range(int'(OP_JCC) + 1, 15));
    if ($urandom_range(0, 2) == 0) it.rm_code = RM_SIB;
    r = $urandom_range(0, 19);
    case (r)
      0: it.displacement = 32'h8000_0000;
      1: it.displacement = 32'h7fff_ffff;
      2: it.displacement = 32'hffff_ff80;
      3: it.displacement = 32'h0000_007f;
      default: ;
    endcase
    // land half of the conditional jumps right on the short/near boundary
    if (it.operation == OP_JCC && $urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0: it.jump_target = near_target(-129);
        1: it.jump_target = near_target(-128);
        2: it.jump_target = near_target(127);
        default: it.jump_target = near_target(128);
      endcase
    end
    return it;
  endfunction

  // Random instruction whose encoding is exactly len bytes (1 to 12)
  function automatic insn_t sized_insn(int len);
    insn_t it;
    bit    sib;
    it  = rand_insn();
    sib = 1'b0;
    case (len)
      1: it.operation = OP_PLAIN;
      2: it.operation = OP_REL8;
      3: begin it.operation = OP_REX_MODRM; it.addr_mode = MOD_DIRECT; end
      4: begin it.operation = OP_REX_MODRM; it.addr_mode = MOD_DISP8; end
      5: it.operation = OP_REL32;
      6: begin it.operation = OP_MODRM_EXT; it.addr_mode = MOD_DISP32; end
      7: begin it.operation = OP_REX_MODRM; it.addr_mode = MOD_DISP32; end
      8: begin it.operation = OP_REX_MODRM; it.addr_mode = MOD_DISP32; sib = 1'b1; end
      9: begin it.operation = OP_MODRM_IMM32; it.addr_mode = MOD_DISP8; sib = 1'b1; end
      10: it.operation = OP_REXW_IMM64;
      11: begin it.operation = OP_MODRM_IMM32; it.addr_mode = MOD_DISP32; end
      default: begin
        it.operation = OP_MODRM_IMM32;
        it.addr_mode = MOD_DISP32;
        sib          = 1'b1;
      end
    endcase
    if (sib) it.rm_code = RM_SIB;
    else if (it.rm_code == RM_SIB) it.rm_code = RM_SIB | 4'h8;
    return it;
  endfunction

  // Enter at a falling edge; hold the beat until it is taken, return at the
  // next falling edge. Push only drops when a gap is drawn, so it never falls
  // and rises within one time step.
  task automatic issue(input insn_t it);
    int gap;
    gap = gap_cycles(quiet_in);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation    <= it.operation;
    in_opcode       <= it.opcode;
    in_reg_code     <= it.reg_code;
    in_rm_code      <= it.rm_code;
    in_addr_mode    <= it.addr_mode;
    in_displacement <= it.displacement;
    in_sib_scale    <= it.sib_scale;
    in_sib_index    <= it.sib_index;
    in_sib_base     <= it.sib_base;
    in_immediate    <= it.immediate;
    in_jump_target  <= it.jump_target;
    in_push         <= 1'b1;
    do @(posedge clk); while (!(in_push && !in_full));
    @(negedge clk);
  endtask

  // Pop side: stall at random, with bursts of steady popping
  initial begin
    int pop_hold;
    int cyc;
    out_pop  = 1'b0;
    pop_hold = 0;
    cyc      = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop  <= 1'b1;
        pop_hold = gap_cycles(quiet_out);
      end
    end
  end

  // Sample both channels at the rising edge: note the accepted instruction
  // first, then check the popped byte against the oldest one due. The
  // watchdog counts cycles in which no beat moves on either side.
  always @(posedge clk) begin
    string msg;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_push && !in_full)
        code_img.accept_item('{in_operation, in_opcode, in_reg_code, in_rm_code,
                               in_addr_mode, in_displacement, in_sib_scale,
                               in_sib_index, in_sib_base, in_immediate,
                               in_jump_target});
      if (out_pop && !out_empty) begin
        msg = code_img.check_beat('{out_code_byte, out_byte_offset, out_last_byte,
                                    out_overflow});
        if (msg != "") report_mismatch(msg);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("x86_64_instruction_encoder_core_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int rem;
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_operation    = '0;
    in_opcode       = '0;
    in_reg_code     = '0;
    in_rm_code      = '0;
    in_addr_mode    = '0;
    in_displacement = '0;
    in_sib_scale    = '0;
    in_sib_index    = '0;
    in_sib_base     = '0;
    in_immediate    = '0;
    in_jump_target  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every form, REX and SIB corner cases
    issue(mk(OP_PLAIN, 8'h00, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_PLAIN, 8'hff, 4'hf, 4'hf, MOD_DIRECT, '1, 2'h3, 4'hf, 4'hf, '1, '1));
    // opcode plus register wraps past 0xff; register bit 3 gives no REX
    issue(mk(OP_PLUS_REG, 8'hf8, 4'hf, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_PLUS_REG, 8'h50, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_REXW_IMM64, 8'hb8, 4'hf, 0, MOD_INDIRECT, 0, 0, 0, 0, '1, 0));
    issue(mk(OP_REXW_IMM64, 8'hb8, 0, 0, MOD_INDIRECT, 0, 0, 0, 0,
             64'h0123_4567_89ab_cdef, 0));
    // register direct: REX.R and REX.B from bit 3 of reg and rm
    issue(mk(OP_REX_MODRM, 8'h89, 4'hf, 4'hf, MOD_DIRECT, 0, 0, 0, 0, 0, 0));
    // SIB byte: REX.X from the index, REX.B from the base
    issue(mk(OP_REX_MODRM, 8'h8b, 0, RM_SIB, MOD_INDIRECT, 0, 2'h3, 4'hf, 4'hd, 0, 0));
    // rm of 4 in register direct mode takes no SIB byte
    issue(mk(OP_REX_MODRM, 8'h8b, 4'h8, RM_SIB, MOD_DIRECT, 0, 2'h3, 4'hf, 4'hf, 0, 0));
    // rm of 12 is not a SIB selector
    issue(mk(OP_REX_MODRM, 8'h8b, 4'h3, 4'hc, MOD_DISP8, 32'hffff_ff80, 0, 4'hf, 4'hf,
             0, 0));
    issue(mk(OP_REX_MODRM, 8'h03, 4'h7, RM_SIB, MOD_DISP32, 32'h8000_0000, 2'h1, 4'h4,
             4'h5, 0, 0));
    issue(mk(OP_MODRM_EXT, 8'hff, 4'h6, RM_SIB, MOD_DISP8, 32'h0000_007f, 0, 4'h8, 0,
             0, 0));
    // the extension form drops bit 3 of reg and rm
    issue(mk(OP_MODRM_EXT, 8'hf7, 4'hf, 4'hf, MOD_DIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_MODRM_IMM32, 8'h81, 0, RM_SIB, MOD_DISP32, 32'h7fff_ffff, 2'h2, 4'hf,
             4'hf, 64'hdead_beef_ffff_ffff, 0));
    issue(mk(OP_MODRM_IMM32, 8'hc7, 0, 4'h3, MOD_INDIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_REL8, 8'heb, 0, 0, MOD_INDIRECT, 32'h0000_007f, 0, 0, 0, 0, 0));
    issue(mk(OP_REL8, 8'heb, 0, 0, MOD_INDIRECT, 32'hffff_ff80, 0, 0, 0, 0, 0));
    issue(mk(OP_REL32, 8'he9, 0, 0, MOD_INDIRECT, 32'h8000_0000, 0, 0, 0, 0, 0));
    issue(mk(OP_REL32, 8'he9, 0, 0, MOD_INDIRECT, 32'h7fff_ffff, 0, 0, 0, 0, 0));
    // unknown forms: dropped with no beat
    issue(mk(OP_JCC + 4'd1, 8'h90, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 0));
    issue(mk(4'hf, 8'h90, 4'hf, 4'hf, MOD_DIRECT, '1, 2'h3, 4'hf, 4'hf, '1, '1));
    // conditional jumps on both sides of the short-form reach
    issue(mk(OP_JCC, 8'h00, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, near_target(127)));
    issue(mk(OP_JCC, 8'hff, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, near_target(128)));
    issue(mk(OP_JCC, 8'h0f, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 12'h000));
    issue(mk(OP_JCC, 8'hf4, 0, 0, MOD_INDIRECT, 0, 0, 0, 0, 0, 12'hfff));

    // Random mix of every form
    for (int i = 0; i < 100; i++) begin
      if (i % 32 == 0) quiet_in = ($urandom_range(0, 3) == 0);
      issue(rand_insn());
    end

    // Fill the code buffer, mostly with long encodings
    while (CodeBytes - code_img.wr_ptr > 48) begin
      if (code_img.wr_ptr % 256 < 10) quiet_in = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 9) issue(sized_insn($urandom_range(10, 12)));
      else issue(rand_insn());
    end

    // Near the end: sometimes fill the buffer exactly, otherwise overrun it
    while (!code_img.buf_full) begin
      rem = CodeBytes - code_img.wr_ptr;
      if (rem >= 1 && rem <= 12 && $urandom_range(0, 1)) issue(sized_insn(rem));
      else issue(rand_insn());
    end

    // Every item of a known form after an overflow gives one overflow beat
    repeat (24) issue(rand_insn());

    in_push <= 1'b0;
    while (code_img.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("x86_64_instruction_encoder_core_tb: clean");
    end else begin
      $display("x86_64_instruction_encoder_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/x86enc_pkg.sv
rtl/core/x86enc_front.sv
rtl/core/x86enc_fifo.sv
rtl/core/x86enc_back.sv
rtl/core/x86_64_instruction_encoder_core.sv
tb/x86_64_instruction_encoder_core_tb.sv
